@@ sv/icmpr_pkg.sv @@
package icmpr_pkg;

   localparam int LANES = 8;
   localparam int BYTE_BITS = 8;
   localparam int WORD_BITS = 64;
   localparam int ADDR_BITS = 32;
   localparam int COUNT_BITS = 4;
   localparam int SUM_BITS = 24;
   localparam int PART_BITS = 16;
   localparam int SUM_ADD_BITS = 19;
   localparam int CKS_SKIP_BYTES = 4;

   localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
   localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   typedef struct packed {
      logic                 store;
      logic                 spill;
      logic [2:0]           slot;
      logic [BYTE_BITS-1:0] value;
      logic [PART_BITS-1:0] sum_part;
      logic                 first;
      logic                 beyond;
   } lane_out_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]   count;
      logic [SUM_ADD_BITS-1:0] sum_add;
      logic                    first_valid;
      logic [BYTE_BITS-1:0]    first_byte;
      logic                    beyond;
      logic                    word_done;
      logic [WORD_BITS-1:0]    write_word;
      logic [WORD_BITS-1:0]    pack_next;
   } merge_out_type;

   function automatic logic [PART_BITS-1:0] fold_checksum(input logic [SUM_BITS-1:0] s);
      logic [PART_BITS:0] a;
      logic [PART_BITS:0] b;
      a = {1'b0, s[PART_BITS-1:0]} + (PART_BITS+1)'(s[SUM_BITS-1:PART_BITS]);
      b = {1'b0, a[PART_BITS-1:0]} + (PART_BITS+1)'(a[PART_BITS]);
      return ~b[PART_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] byte_mask(input logic [COUNT_BITS-1:0] nb);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int j = 0; j < LANES; j++) begin
         if (COUNT_BITS'(j) < nb) begin
            m[WORD_BITS-1-BYTE_BITS*j -: BYTE_BITS] = '1;
         end
      end
      return m;
   endfunction

endpackage

@@ sv/icmpr_req_if.sv @@
interface icmpr_req_if import icmpr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_BITS-1:0]  data_word;
   logic [COUNT_BITS-1:0] byte_count;
   logic                  last;
   logic [ADDR_BITS-1:0]  source_address;

   modport source (output valid, output data_word, output byte_count, output last,
                   output source_address, input ready);
   modport sink (input valid, input data_word, input byte_count, input last,
                 input source_address, output ready);
endinterface

@@ sv/icmpr_rsp_if.sv @@
interface icmpr_rsp_if import icmpr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [WORD_BITS-1:0]  reply_word;
   logic [COUNT_BITS-1:0] reply_bytes;
   logic                  reply_last;
   logic [ADDR_BITS-1:0]  destination_address;

   modport source (output valid, output result_kind, output reply_word, output reply_bytes,
                   output reply_last, output destination_address, input ready);
   modport sink (input valid, input result_kind, input reply_word, input reply_bytes,
                 input reply_last, input destination_address, output ready);
endinterface

@@ sv/icmp_echo_responder_core.sv @@
// Channel       | Dir | Handshake   | Payload
// req_channel   | in  | valid/ready | data_word, byte_count, last, source_address
// rsp_channel   | out | valid/ready | result_kind, reply_word, reply_bytes, reply_last,
//               |     |             | destination_address
//
// An input word is taken whole whenever the core is idle; eight byte lanes place and sum its bytes.
// An echo reply then drains word by word: ST_READ waits on the registered read of the
// message memory, ST_SEND holds it through any output stall; a notice skips ST_READ.
// Input is held off while a reply or notice drains.
// Reset is synchronous; the message memory is not cleared, and no clearing pass runs.
module icmp_echo_responder_core import icmpr_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = 512
) (
   input logic         clock,
   input logic         reset,
   icmpr_req_if.sink   req_channel,
   icmpr_rsp_if.source rsp_channel
);

   localparam int StoreDepth = (MAX_MESSAGE_BYTES + LANES - 1) / LANES;
   localparam int AddrWidth = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
   localparam int TotalWidth = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int PosWidth = TotalWidth + 1;
   localparam int CountWidth = $clog2(StoreDepth + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [TotalWidth-1:0] total_ff, total_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [ADDR_BITS-1:0]  sender_ff, sender_in;
   logic [BYTE_BITS-1:0]  type_ff, type_in;
   logic                  ovf_ff, ovf_in;
   logic [WORD_BITS-1:0]  pack_ff, pack_in;
   logic [TotalWidth-1:0] drain_total_ff, drain_total_in;
   logic [CountWidth-1:0] word_idx_ff, word_idx_in;
   logic [PART_BITS-1:0]  cks_ff, cks_in;
   logic                  notice_ff, notice_in;
   logic [WORD_BITS-1:0]  rd_data_ff;

   logic [WORD_BITS-1:0]  store_mem [StoreDepth];

   lane_out_type          lane_res [LANES];
   merge_out_type         merged;

   logic                  accept;
   logic [COUNT_BITS-1:0] byte_count_eff;
   logic [TotalWidth-1:0] total_next;
   logic [SUM_BITS-1:0]   sum_next;
   logic                  ovf_next;
   logic [BYTE_BITS-1:0]  type_next;
   logic                  wr_en;
   logic [AddrWidth-1:0]  wr_addr;
   logic [AddrWidth-1:0]  rd_addr;
   logic [TotalWidth-1:0] drain_rem;
   logic                  drain_last;
   logic [COUNT_BITS-1:0] drain_bytes;
   logic                  use_pack;
   logic [WORD_BITS-1:0]  word_raw;

   assign byte_count_eff = (req_channel.byte_count > COUNT_BITS'(LANES)) ?
                           COUNT_BITS'(LANES) : req_channel.byte_count;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      icmpr_lane #(
         .MaxBytes (MAX_MESSAGE_BYTES),
         .PosWidth (PosWidth),
         .LaneIndex(g)
      ) u_lane (
         .data_byte     (req_channel.data_word[WORD_BITS-1-BYTE_BITS*g -: BYTE_BITS]),
         .byte_count_eff(byte_count_eff),
         .base_pos      (PosWidth'(total_ff)),
         .overflow      (ovf_ff),
         .lane_res      (lane_res[g])
      );
   end

   icmpr_merge u_merge (
      .lane_res (lane_res),
      .pack_word(pack_ff),
      .base_slot(total_ff[2:0]),
      .merged   (merged)
   );

   assign req_channel.ready = (state_ff == ST_IDLE);
   assign accept = req_channel.valid && req_channel.ready;

   assign total_next = total_ff + TotalWidth'(merged.count);
   assign sum_next = ((total_ff == '0) ? '0 : sum_ff) + SUM_BITS'(merged.sum_add);
   assign ovf_next = ovf_ff || merged.beyond;
   assign type_next = merged.first_valid ? merged.first_byte : type_ff;

   assign wr_en = accept && merged.word_done;
   assign wr_addr = AddrWidth'(total_ff >> 3);
   assign rd_addr = AddrWidth'(word_idx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= merged.write_word;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   assign drain_rem = drain_total_ff - TotalWidth'({word_idx_ff, 3'b000});
   assign drain_last = drain_rem <= TotalWidth'(LANES);
   assign drain_bytes = drain_last ? drain_rem[COUNT_BITS-1:0] : COUNT_BITS'(LANES);
   assign use_pack = (word_idx_ff == CountWidth'(drain_total_ff >> 3));

   always_comb begin
      if (word_idx_ff == '0) begin
         word_raw = {16'h0000, cks_ff, rd_data_ff[31:0]};
      end else if (use_pack) begin
         word_raw = pack_ff;
      end else begin
         word_raw = rd_data_ff;
      end
   end

   assign rsp_channel.valid = (state_ff == ST_SEND);
   assign rsp_channel.result_kind = notice_ff ? KIND_NOTICE : KIND_DATA;
   assign rsp_channel.reply_word = notice_ff ? '0 : (word_raw & byte_mask(drain_bytes));
   assign rsp_channel.reply_bytes = notice_ff ? '0 : drain_bytes;
   assign rsp_channel.reply_last = notice_ff || drain_last;
   assign rsp_channel.destination_address = sender_ff;

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      sum_in = sum_ff;
      sender_in = sender_ff;
      type_in = type_ff;
      ovf_in = ovf_ff;
      pack_in = pack_ff;
      drain_total_in = drain_total_ff;
      word_idx_in = word_idx_ff;
      cks_in = cks_ff;
      notice_in = notice_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((total_ff == '0) && !ovf_ff) begin
                  sender_in = req_channel.source_address;
               end
               type_in = type_next;
               pack_in = merged.pack_next;
               sum_in = sum_next;
               if (req_channel.last) begin
                  total_in = '0;
                  ovf_in = 1'b0;
                  drain_total_in = total_next;
                  word_idx_in = '0;
                  if (!ovf_next && (total_next >= TotalWidth'(LANES))) begin
                     if (type_next == TYPE_ECHO_REQUEST) begin
                        notice_in = 1'b0;
                        state_in = ST_READ;
                     end else if (type_next == TYPE_ECHO_REPLY) begin
                        notice_in = 1'b1;
                        state_in = ST_SEND;
                     end
                  end
               end else begin
                  total_in = total_next;
                  ovf_in = ovf_next;
               end
            end
         end
         ST_READ: begin
            cks_in = fold_checksum(sum_ff);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_channel.ready) begin
               if (notice_ff || drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  word_idx_in = word_idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         sum_ff <= '0;
         sender_ff <= '0;
         type_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         sum_ff <= sum_in;
         sender_ff <= sender_in;
         type_ff <= type_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff <= pack_in;
      drain_total_ff <= drain_total_in;
      word_idx_ff <= word_idx_in;
      cks_ff <= cks_in;
      notice_ff <= notice_in;
   end

endmodule

@@ sv/icmpr_lane.sv @@
module icmpr_lane import icmpr_pkg::*; #(
   parameter int MaxBytes = 512,
   parameter int PosWidth = 11,
   parameter int LaneIndex = 0
) (
   input  logic [BYTE_BITS-1:0]  data_byte,
   input  logic [COUNT_BITS-1:0] byte_count_eff,
   input  logic [PosWidth-1:0]   base_pos,
   input  logic                  overflow,
   output lane_out_type          lane_res
);

   logic [PosWidth-1:0] pos;
   logic [3:0]          slot_sum;
   logic                requested;
   logic                in_range;
   logic                store;

   assign pos = base_pos + PosWidth'(LaneIndex);
   assign slot_sum = {1'b0, base_pos[2:0]} + 4'(LaneIndex);
   assign requested = COUNT_BITS'(LaneIndex) < byte_count_eff;
   assign in_range = pos < PosWidth'(MaxBytes);
   assign store = !overflow && requested && in_range;

   always_comb begin
      lane_res.store = store;
      lane_res.spill = slot_sum[3];
      lane_res.slot = slot_sum[2:0];
      lane_res.value = data_byte;
      lane_res.first = store && (pos == '0);
      lane_res.beyond = requested && (overflow || !in_range);
      if (store && (pos >= PosWidth'(CKS_SKIP_BYTES))) begin
         lane_res.sum_part = pos[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
      end else begin
         lane_res.sum_part = '0;
      end
   end

endmodule

@@ sv/icmpr_merge.sv @@
module icmpr_merge import icmpr_pkg::*; (
   input  lane_out_type         lane_res [LANES],
   input  logic [WORD_BITS-1:0] pack_word,
   input  logic [2:0]           base_slot,
   output merge_out_type        merged
);

   logic [WORD_BITS-1:0]    cur_word;
   logic [WORD_BITS-1:0]    nxt_word;
   logic [COUNT_BITS-1:0]   cnt;
   logic [SUM_ADD_BITS-1:0] sum;
   logic                    first_valid;
   logic [BYTE_BITS-1:0]    first_byte;
   logic                    beyond;

   always_comb begin
      cur_word = pack_word;
      nxt_word = pack_word;
      cnt = '0;
      sum = '0;
      first_valid = 1'b0;
      first_byte = '0;
      beyond = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         if (lane_res[i].store) begin
            cnt = cnt + 1'b1;
            sum = sum + SUM_ADD_BITS'(lane_res[i].sum_part);
            if (lane_res[i].spill) begin
               nxt_word[WORD_BITS-1-BYTE_BITS*lane_res[i].slot -: BYTE_BITS] = lane_res[i].value;
            end else begin
               cur_word[WORD_BITS-1-BYTE_BITS*lane_res[i].slot -: BYTE_BITS] = lane_res[i].value;
            end
         end
         if (lane_res[i].first) begin
            first_valid = 1'b1;
            first_byte = lane_res[i].value;
         end
         if (lane_res[i].beyond) begin
            beyond = 1'b1;
         end
      end
   end

   always_comb begin
      merged.count = cnt;
      merged.sum_add = sum;
      merged.first_valid = first_valid;
      merged.first_byte = first_byte;
      merged.beyond = beyond;
      merged.word_done = ({1'b0, base_slot} + cnt) >= 4'd8;
      merged.write_word = cur_word;
      merged.pack_next = merged.word_done ? nxt_word : cur_word;
   end

endmodule

@@ sv/icmpr_checker.sv @@
module icmpr_checker import icmpr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_result_kind,
   input logic [WORD_BITS-1:0]  rsp_reply_word,
   input logic [COUNT_BITS-1:0] rsp_reply_bytes,
   input logic                  rsp_reply_last,
   input logic [ADDR_BITS-1:0]  rsp_destination_address
);

   // A transaction waiting on the output keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_word) &&
      $stable(rsp_reply_bytes) && $stable(rsp_reply_last) && $stable(rsp_result_kind) &&
      $stable(rsp_destination_address))
      else $error("output transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a reply is draining");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_NOTICE) |->
      (rsp_reply_bytes == '0) && rsp_reply_last && (rsp_reply_word == '0))
      else $error("malformed notice");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_DATA) |->
      (rsp_reply_bytes != '0) && (rsp_reply_bytes <= COUNT_BITS'(LANES)))
      else $error("reply word byte count out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_reply_last |=> !rsp_valid && req_ready)
      else $error("output continued after the final transaction");

endmodule

bind icmp_echo_responder_core icmpr_checker u_icmpr_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_ready              (req_channel.ready),
   .rsp_valid              (rsp_channel.valid),
   .rsp_ready              (rsp_channel.ready),
   .rsp_result_kind        (rsp_channel.result_kind),
   .rsp_reply_word         (rsp_channel.reply_word),
   .rsp_reply_bytes        (rsp_channel.reply_bytes),
   .rsp_reply_last         (rsp_channel.reply_last),
   .rsp_destination_address(rsp_channel.destination_address)
);
